// ===== src/ult_pkg.sv =====
// ============================================================================
// ult_pkg: shared definitions for the unsorted list table
// Sizes, operation and status codes, the result and memory request types,
// and width conversion helpers used by the list sequencer and the top level.
// ============================================================================
package ult_pkg;

    // Table sizing.
    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    // Fixed widths of the channel fields.
    localparam int MODE_W   = 3;
    localparam int ITEM_W   = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 5;

    // Operation codes carried in the mode field.
    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT     = 3'd0,
        MODE_SEARCH     = 3'd1,
        MODE_DELETE     = 3'd2,
        MODE_NEXT       = 3'd3,
        MODE_RESET_ITER = 3'd4,
        MODE_CLEAR      = 3'd5
    } t_mode;

    // Status codes returned with every result beat.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_EMPTY     = 2'd3
    } t_status;

    // One result beat.
    typedef struct packed {
        logic              hit;
        t_status           status;
        logic [ITEM_W-1:0] read_value;
        logic [LEN_W-1:0]  length;
    } t_result;

    // Request to the entry memory: one write port and one read port.
    typedef struct packed {
        logic                   we;
        logic [IDX_W-1:0]       waddr;
        logic [VALUE_WIDTH-1:0] wdata;
        logic [IDX_W-1:0]       raddr;
    } t_mem_req;

    // Input item value to stored value width (truncate or zero extend).
    function automatic logic [VALUE_WIDTH-1:0] to_value(input logic [ITEM_W-1:0] item);
        logic [VALUE_WIDTH+ITEM_W-1:0] ext;
        ext = {{VALUE_WIDTH{1'b0}}, item};
        return ext[VALUE_WIDTH-1:0];
    endfunction

    // Stored value to output field width.
    function automatic logic [ITEM_W-1:0] to_item(input logic [VALUE_WIDTH-1:0] value);
        logic [VALUE_WIDTH+ITEM_W-1:0] ext;
        ext = {{ITEM_W{1'b0}}, value};
        return ext[ITEM_W-1:0];
    endfunction

    // Entry count to length field width.
    function automatic logic [LEN_W-1:0] to_len(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+LEN_W-1:0] ext;
        ext = {{LEN_W{1'b0}}, cnt};
        return ext[LEN_W-1:0];
    endfunction

endpackage

// ===== src/ult_if.sv =====
// ============================================================================
// ult_if: channel interfaces of the unsorted list table
// Valid/ready channels for command beats in and result beats out.
// ============================================================================

// Command channel: one operation per beat.
interface ult_in_if;
    logic                       valid;
    logic                       ready;
    logic [ult_pkg::MODE_W-1:0] mode;
    logic [ult_pkg::ITEM_W-1:0] item_value;

    modport source (output valid, output mode, output item_value, input ready);
    modport sink   (input valid, input mode, input item_value, output ready);
endinterface

// Result channel: one result beat per command beat.
interface ult_out_if;
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic [ult_pkg::STATUS_W-1:0] status;
    logic [ult_pkg::ITEM_W-1:0]   read_value;
    logic [ult_pkg::LEN_W-1:0]    length;

    modport source (output valid, output hit, output status, output read_value,
                    output length, input ready);
    modport sink   (input valid, input hit, input status, input read_value,
                    input length, output ready);
endinterface

// ===== src/ult_ram.sv =====
// ============================================================================
// ult_ram: simple dual port RAM
// One write port and one read port, read data registered.
// ============================================================================
module ult_ram #(
    parameter int  DEPTH = 16,
    parameter int  WIDTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/ult_seq.sv =====
// ============================================================================
// ult_seq: list sequencer
// Runs one operation at a time against the entry memory: scans for a match,
// shifts entries up on insert and down on delete, and keeps count and cursor.
// ============================================================================
module ult_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ult_in_if.sink                        i_in,
    output ult_pkg::t_mem_req             o_mem,
    input  logic [ult_pkg::VALUE_WIDTH-1:0] i_rdata,
    output logic                          o_res_vld,
    output ult_pkg::t_result              o_res,
    input  logic                          i_res_rdy
);
    import ult_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_READ,
        S_DONE
    } t_state;

    t_state                 r_state, n_state;
    logic [MODE_W-1:0]      r_mode, n_mode;
    logic [VALUE_WIDTH-1:0] r_value, n_value;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [CNT_W-1:0]       r_cursor, n_cursor;
    logic                   r_active, n_active;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic                   r_more, n_more;
    logic                   r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]       r_rd_tag, n_rd_tag;
    logic [IDX_W-1:0]       r_pos, n_pos;
    logic                   r_hit, n_hit;
    t_status                r_status, n_status;
    logic [ITEM_W-1:0]      r_rdv, n_rdv;

    logic [IDX_W-1:0]       start_idx;
    logic [CNT_W-1:0]       idx_inc;
    logic [CNT_W-1:0]       tag_inc;
    logic [CNT_W-1:0]       cur_dec;
    logic [CNT_W-1:0]       count_dec;

    // Helper values, some shared by several states.
    assign count_dec = r_count - 1'b1;
    assign idx_inc   = CNT_W'(r_idx) + 1'b1;
    assign tag_inc   = CNT_W'(r_rd_tag) + 1'b1;
    assign cur_dec   = (CNT_W'(r_pos) < r_cursor) ? (r_cursor - 1'b1) : r_cursor;
    assign start_idx = (!r_active || (r_cursor >= r_count)) ? '0 : IDX_W'(r_cursor);

    // Next state and memory request.
    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_value  = r_value;
        n_count  = r_count;
        n_cursor = r_cursor;
        n_active = r_active;
        n_idx    = r_idx;
        n_more   = r_more;
        n_rd_vld = 1'b0;
        n_rd_tag = r_rd_tag;
        n_pos    = r_pos;
        n_hit    = r_hit;
        n_status = r_status;
        n_rdv    = r_rdv;
        o_mem.we    = 1'b0;
        o_mem.waddr = '0;
        o_mem.wdata = r_value;
        o_mem.raddr = r_idx;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_mode  = i_in.mode;
                    n_value = to_value(i_in.item_value);
                    n_state = S_START;
                end
            end

            S_START: begin
                n_hit    = 1'b0;
                n_status = STATUS_OK;
                n_rdv    = '0;
                case (r_mode)
                    MODE_INSERT: begin
                        if (r_count >= CNT_W'(CAPACITY)) begin
                            n_status = STATUS_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_idx   = IDX_W'(count_dec);
                            n_more  = (r_count != '0);
                            n_state = S_SHIFT_UP;
                        end
                    end
                    MODE_SEARCH, MODE_DELETE: begin
                        if (r_count == '0) begin
                            if (r_mode == MODE_DELETE) begin
                                n_status = STATUS_NOT_FOUND;
                            end
                            n_state = S_DONE;
                        end else begin
                            n_idx   = '0;
                            n_more  = 1'b1;
                            n_state = S_SCAN;
                        end
                    end
                    MODE_NEXT: begin
                        if (r_count == '0) begin
                            n_status = STATUS_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            o_mem.raddr = start_idx;
                            n_idx       = start_idx;
                            n_state     = S_READ;
                        end
                    end
                    MODE_RESET_ITER: begin
                        n_cursor = '0;
                        n_active = 1'b0;
                        n_state  = S_DONE;
                    end
                    MODE_CLEAR: begin
                        n_count  = '0;
                        n_cursor = '0;
                        n_active = 1'b0;
                        n_state  = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            // Walk entries from the front, compare each entry in the cycle after its read.
            S_SCAN: begin
                if (r_more) begin
                    o_mem.raddr = r_idx;
                    n_rd_vld    = 1'b1;
                    n_rd_tag    = r_idx;
                    n_idx       = r_idx + 1'b1;
                    n_more      = idx_inc < r_count;
                end
                if (r_rd_vld) begin
                    if (i_rdata == r_value) begin
                        n_rd_vld = 1'b0;
                        if (r_mode == MODE_DELETE) begin
                            n_pos   = r_rd_tag;
                            n_idx   = IDX_W'(tag_inc);
                            n_more  = tag_inc < r_count;
                            n_state = S_SHIFT_DN;
                        end else begin
                            n_hit   = 1'b1;
                            n_state = S_DONE;
                        end
                    end else if (CNT_W'(r_rd_tag) == count_dec) begin
                        n_rd_vld = 1'b0;
                        if (r_mode == MODE_DELETE) begin
                            n_status = STATUS_NOT_FOUND;
                        end
                        n_state = S_DONE;
                    end
                end
            end

            // Move entries back by one from the tail, then store at the front.
            S_SHIFT_UP: begin
                if (r_rd_vld) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_rd_tag + 1'b1;
                    o_mem.wdata = i_rdata;
                end
                if (r_more) begin
                    o_mem.raddr = r_idx;
                    n_rd_vld    = 1'b1;
                    n_rd_tag    = r_idx;
                    n_idx       = r_idx - 1'b1;
                    n_more      = (r_idx != '0);
                end else if (!r_rd_vld) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = '0;
                    o_mem.wdata = r_value;
                    n_count     = r_count + 1'b1;
                    if (r_active) begin
                        n_cursor = r_cursor + 1'b1;
                    end
                    n_state = S_DONE;
                end
            end

            // Close the gap behind the deleted entry.
            S_SHIFT_DN: begin
                if (r_rd_vld) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_rd_tag - 1'b1;
                    o_mem.wdata = i_rdata;
                end
                if (r_more) begin
                    o_mem.raddr = r_idx;
                    n_rd_vld    = 1'b1;
                    n_rd_tag    = r_idx;
                    n_idx       = r_idx + 1'b1;
                    n_more      = idx_inc < r_count;
                end else if (!r_rd_vld) begin
                    n_hit   = 1'b1;
                    n_count = count_dec;
                    if (r_active) begin
                        if (cur_dec >= count_dec) begin
                            n_cursor = '0;
                            n_active = 1'b0;
                        end else begin
                            n_cursor = cur_dec;
                        end
                    end
                    n_state = S_DONE;
                end
            end

            // Return the entry at the cursor and advance it.
            S_READ: begin
                n_rdv = to_item(i_rdata);
                if (idx_inc >= r_count) begin
                    n_cursor = '0;
                    n_active = 1'b0;
                end else begin
                    n_cursor = idx_inc;
                    n_active = 1'b1;
                end
                n_state = S_DONE;
            end

            S_DONE: begin
                if (i_res_rdy) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cursor <= '0;
            r_active <= 1'b0;
            r_more   <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_active <= n_active;
            r_more   <= n_more;
            r_rd_vld <= n_rd_vld;
        end
        r_mode   <= n_mode;
        r_value  <= n_value;
        r_idx    <= n_idx;
        r_rd_tag <= n_rd_tag;
        r_pos    <= n_pos;
        r_hit    <= n_hit;
        r_status <= n_status;
        r_rdv    <= n_rdv;
    end

    // Handshake and result.
    assign i_in.ready       = (r_state == S_IDLE);
    assign o_res_vld        = (r_state == S_DONE);
    assign o_res.hit        = r_hit;
    assign o_res.status     = r_status;
    assign o_res.read_value = r_rdv;
    assign o_res.length     = to_len(r_count);

    // The entry count never passes the table size.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A running iterator always points at a stored entry.
    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_cursor < r_count))
        else $error("active cursor beyond the last entry");

    // The memory is written only while shifting entries.
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.we |-> (r_state == S_SHIFT_UP || r_state == S_SHIFT_DN))
        else $error("entry write outside a shift");

    // Read data in flight is only tracked in the walking states.
    a_read_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == S_SCAN || r_state == S_SHIFT_UP ||
                      r_state == S_SHIFT_DN))
        else $error("read in flight outside a walk");

endmodule

// ===== src/ult_out_reg.sv =====
// ============================================================================
// ult_out_reg: result output register
// Holds one result beat for the receiver so the sequencer can move on.
// ============================================================================
module ult_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_res_vld,
    input  ult_pkg::t_result i_res,
    output logic             o_res_rdy,
    ult_out_if.source        o_out
);
    import ult_pkg::*;

    logic    r_vld;
    t_result r_data;

    // Load a new beat whenever the register is empty or being drained.
    assign o_res_rdy = !r_vld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_res_rdy) begin
            r_vld <= i_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_vld && o_res_rdy) begin
            r_data <= i_res;
        end
    end

    assign o_out.valid      = r_vld;
    assign o_out.hit        = r_data.hit;
    assign o_out.status     = r_data.status;
    assign o_out.read_value = r_data.read_value;
    assign o_out.length     = r_data.length;

endmodule

// ===== src/unsorted_list_table_unit.sv =====
// ============================================================================
// unsorted_list_table_unit: list of values with an iterator
// Stores up to CAPACITY values newest first, with insert, search, delete,
// get next, iterator reset and clear operations.
// ============================================================================
// Usage:
//   i_in carries one command beat (mode, item_value); o_out returns exactly
//   one result beat (hit, status, read_value, length) for each command, in
//   order. A command is taken only while the previous one is finished.
//   Entries live in a one-port-read, one-port-write memory with registered
//   read data; the sequencer walks it one entry per cycle.
//   Iterator reset, clear, undecoded modes, full insert, empty search/delete
//   and get next need no walk; insert into a non-empty list and delete walk
//   the stored entries, and a search walks until its match or the last entry.
//   The next command can be taken in the cycle after the result is handed
//   to the output register, so a command holds the sequencer until its
//   result is handed on; while the receiver takes results, the memory walk sets the rate of commands.
//   Reset empties the list and stops the iterator; no memory pass is needed.
//   When the receiver stalls, one result waits in the output register and
//   the next command still runs; its result then waits in the sequencer.
// ============================================================================
module unsorted_list_table_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ult_in_if.sink    i_in,
    ult_out_if.source o_out
);
    import ult_pkg::*;

    t_mem_req               mem_req;
    logic [VALUE_WIDTH-1:0] mem_rdata;
    logic                   res_vld;
    logic                   res_rdy;
    t_result                res;

    // Operation sequencer.
    ult_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_mem     (mem_req),
        .i_rdata   (mem_rdata),
        .o_res_vld (res_vld),
        .o_res     (res),
        .i_res_rdy (res_rdy)
    );

    // Entry storage.
    ult_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

    // Result holding register.
    ult_out_reg u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_res_vld (res_vld),
        .i_res     (res),
        .o_res_rdy (res_rdy),
        .o_out     (o_out)
    );

endmodule
